@@ sv/gcd_pkg.sv @@
// Shared types, codes and constants for the GLB chunk deframer.
package gcd_pkg;

  localparam logic [31:0] GLB_MAGIC    = 32'h4654_6C67;
  localparam logic [31:0] GLB_JSON     = 32'h4E4F_534A;
  localparam logic [31:0] GLB_BIN      = 32'h004E_4942;
  localparam logic [31:0] GLB_VERSION  = 32'd2;
  localparam logic [31:0] GLB_HDR_LEN  = 32'd12;
  localparam logic [32:0] GLB_MIN_SIZE = 33'd20;

  // Byte position of the last byte of each file header word
  localparam logic [31:0] POS_MAGIC_END   = 32'd3;
  localparam logic [31:0] POS_VERSION_END = 32'd7;
  localparam logic [31:0] POS_LENGTH_END  = 32'd11;

  // Chunk header byte count at which the length word is complete
  localparam logic [2:0] HCNT_LEN_DONE = 3'd4;

  typedef enum logic [2:0] {
    KIND_HDR     = 3'd0,
    KIND_JSON    = 3'd1,
    KIND_BIN     = 3'd2,
    KIND_UNKNOWN = 3'd3,
    KIND_IGNORED = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    CLS_NONE    = 2'd0,
    CLS_JSON    = 2'd1,
    CLS_BIN     = 2'd2,
    CLS_UNKNOWN = 2'd3
  } chunk_class_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SMALL    = 3'd1,
    ST_MAGIC    = 3'd2,
    ST_VERSION  = 3'd3,
    ST_LENGTH   = 3'd4,
    ST_OVERRUN  = 3'd5,
    ST_NO_JSON  = 3'd6
  } status_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    kind_t      byte_kind;
    logic       chunk_start;
    logic       error_seen;
    status_t    final_status;
    logic       is_final;
  } result_t;

endpackage

@@ sv/gcd_parse.sv @@
// Deframer state and the per-byte tagging logic.
module gcd_parse (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  logic [7:0]      data_byte,
  input  logic            is_last,
  output gcd_pkg::result_t result
);
  import gcd_pkg::*;

  logic [31:0]  byte_position, byte_position_next;
  logic [31:0]  word_shift, word_shift_next;
  logic [31:0]  declared_length, declared_length_next;
  logic [31:0]  chunk_remaining, chunk_remaining_next;
  logic [2:0]   chunk_header_count, chunk_header_count_next;
  chunk_class_t chunk_class, chunk_class_next;
  logic         json_nonempty, json_nonempty_next;
  status_t      error_code, error_code_next;

  logic [31:0]  shifted;
  logic [31:0]  rem_dec;
  logic [2:0]   hcnt_inc;
  logic         hdr_no_fit;
  logic         chunk_overrun;
  logic [32:0]  file_size;
  chunk_class_t new_class;
  kind_t        kind;
  logic         start;
  status_t      status;

  always_comb begin
    byte_position_next      = byte_position;
    word_shift_next         = word_shift;
    declared_length_next    = declared_length;
    chunk_remaining_next    = chunk_remaining;
    chunk_header_count_next = chunk_header_count;
    chunk_class_next        = chunk_class;
    json_nonempty_next      = json_nonempty;
    error_code_next         = error_code;
    kind                    = KIND_IGNORED;
    start                   = 1'b0;
    new_class               = CLS_UNKNOWN;

    shifted       = {data_byte, word_shift[31:8]};
    rem_dec       = chunk_remaining - 32'd1;
    hcnt_inc      = chunk_header_count + 3'd1;
    hdr_no_fit    = ({1'b0, byte_position} + 33'd8) > {1'b0, declared_length};
    chunk_overrun = ({2'b0, byte_position} + 34'd1 + {2'b0, chunk_remaining})
                    > {2'b0, declared_length};

    priority if (byte_position < GLB_HDR_LEN) begin
      kind = KIND_HDR;
      word_shift_next = shifted;
      priority if (byte_position == POS_MAGIC_END && shifted != GLB_MAGIC &&
                   error_code == ST_OK) begin
        error_code_next = ST_MAGIC;
      end else if (byte_position == POS_VERSION_END && shifted != GLB_VERSION &&
                   error_code == ST_OK) begin
        error_code_next = ST_VERSION;
      end else if (byte_position == POS_LENGTH_END) begin
        declared_length_next = shifted;
      end else begin
      end
    end else if (error_code != ST_OK || byte_position >= declared_length) begin
      kind = KIND_IGNORED;
    end else if (chunk_class != CLS_NONE && chunk_header_count == 3'd0) begin
      kind  = kind_t'({1'b0, chunk_class});
      start = (chunk_remaining == word_shift);
      chunk_remaining_next = rem_dec;
      if (rem_dec == 32'd0) begin
        chunk_class_next = CLS_NONE;
      end
    end else if (chunk_header_count == 3'd0 && hdr_no_fit) begin
      kind = KIND_IGNORED;
    end else begin
      kind = KIND_HDR;
      word_shift_next = shifted;
      chunk_header_count_next = hcnt_inc;
      if (hcnt_inc == HCNT_LEN_DONE) begin
        chunk_remaining_next = shifted;
      end else if (hcnt_inc == 3'd0) begin
        if (chunk_overrun) begin
          error_code_next      = ST_OVERRUN;
          chunk_remaining_next = 32'd0;
          chunk_class_next     = CLS_NONE;
        end else begin
          if (shifted == GLB_JSON) begin
            new_class          = CLS_JSON;
            json_nonempty_next = (chunk_remaining != 32'd0);
          end else if (shifted == GLB_BIN) begin
            new_class = CLS_BIN;
          end
          word_shift_next  = chunk_remaining;
          chunk_class_next = (chunk_remaining != 32'd0) ? new_class : CLS_NONE;
        end
      end
    end

    if (byte_position != 32'hFFFF_FFFF) begin
      byte_position_next = byte_position + 32'd1;
    end

    file_size = {1'b0, byte_position} + 33'd1;
    status    = ST_OK;
    if (is_last) begin
      priority if (file_size < GLB_MIN_SIZE) begin
        status = ST_SMALL;
      end else if (error_code_next == ST_MAGIC || error_code_next == ST_VERSION) begin
        status = error_code_next;
      end else if ({1'b0, declared_length_next} > file_size) begin
        status = ST_LENGTH;
      end else if (error_code_next == ST_OVERRUN) begin
        status = ST_OVERRUN;
      end else if (!json_nonempty_next) begin
        status = ST_NO_JSON;
      end else begin
        status = ST_OK;
      end
    end

    result.payload_byte = data_byte;
    result.byte_kind    = kind;
    result.chunk_start  = start;
    result.error_seen   = (error_code_next != ST_OK) || (status != ST_OK);
    result.final_status = status;
    result.is_final     = is_last;
  end

  always_ff @(posedge clk) begin
    if (rst || (step && is_last)) begin
      byte_position      <= '0;
      word_shift         <= '0;
      declared_length    <= '0;
      chunk_remaining    <= '0;
      chunk_header_count <= '0;
      chunk_class        <= CLS_NONE;
      json_nonempty      <= 1'b0;
      error_code         <= ST_OK;
    end else if (step) begin
      byte_position      <= byte_position_next;
      word_shift         <= word_shift_next;
      declared_length    <= declared_length_next;
      chunk_remaining    <= chunk_remaining_next;
      chunk_header_count <= chunk_header_count_next;
      chunk_class        <= chunk_class_next;
      json_nonempty      <= json_nonempty_next;
      error_code         <= error_code_next;
    end
  end

endmodule

@@ sv/gcd_out_reg.sv @@
// Result register with valid/ready handshake toward the consumer.
module gcd_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  gcd_pkg::result_t result_in,
  output logic             full,
  output gcd_pkg::result_t result_out,
  input  logic             take
);
  import gcd_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (load) begin
      full <= 1'b1;
    end else if (take) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_out <= result_in;
    end
  end

endmodule

@@ sv/glb_chunk_deframer.sv @@
// Top level of the GLB (binary glTF) container chunk deframer.
// Bytes of a GLB file enter one byte per handshake on the input channel; every
// accepted byte leaves as exactly one result word through a single result
// register. The input is ready whenever that register is empty or is being
// emptied in the same cycle, so a steady stream moves at one byte per clock
// while the consumer keeps out_ready high; the rate is set by the update of the
// parser state (position, word assembly, chunk counters), which is done in the
// same cycle the byte is accepted. Each result carries the byte, its kind
// (file or chunk header, JSON, BIN, unknown chunk payload, or ignored), a flag
// on the first payload byte of each chunk, and a sticky error flag. The byte
// marked is_last carries the final status (too small, bad magic, bad version,
// declared length beyond the file, chunk overrun, missing or empty JSON) and
// returns the parser to its reset state so the next byte opens a new file.
// There is no clearing pass after reset.
module glb_chunk_deframer (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       is_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] payload_byte,
  output logic [2:0] byte_kind,
  output logic       chunk_start,
  output logic       error_seen,
  output logic [2:0] final_status,
  output logic       is_final
);
  import gcd_pkg::*;

  logic    accept;
  result_t step_result;
  result_t held;

  // Ready as long as the result register frees up this cycle
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  gcd_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .step      (accept),
    .data_byte (data_byte),
    .is_last   (is_last),
    .result    (step_result)
  );

  gcd_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .load       (accept),
    .result_in  (step_result),
    .full       (out_valid),
    .result_out (held),
    .take       (out_ready)
  );

  assign payload_byte = held.payload_byte;
  assign byte_kind    = held.byte_kind;
  assign chunk_start  = held.chunk_start;
  assign error_seen   = held.error_seen;
  assign final_status = held.final_status;
  assign is_final     = held.is_final;

endmodule

@@ sv/gcd_checker.sv @@
// Port-level checks for the GLB chunk deframer, bound to the top level.
module gcd_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] payload_byte,
  input logic [2:0] byte_kind,
  input logic       chunk_start,
  input logic       error_seen,
  input logic [2:0] final_status,
  input logic       is_final
);
  import gcd_pkg::*;

  // A stalled result word holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(payload_byte) &&
      $stable(byte_kind) && $stable(final_status))
    else $error("result word changed while stalled");

  // An empty result register never blocks the input
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  a_status_final: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_final |-> final_status == ST_OK)
    else $error("final status outside last byte");

  a_status_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && final_status != ST_OK |-> error_seen)
    else $error("bad final status without error flag");

  a_start_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && chunk_start |-> byte_kind == KIND_JSON || byte_kind == KIND_BIN ||
      byte_kind == KIND_UNKNOWN)
    else $error("chunk start on a non-payload byte");

endmodule

bind glb_chunk_deframer gcd_checker u_gcd_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .payload_byte (payload_byte),
  .byte_kind    (byte_kind),
  .chunk_start  (chunk_start),
  .error_seen   (error_seen),
  .final_status (final_status),
  .is_final     (is_final)
);
